@@ sv/assert_macros.svh @@
// Assertion macros used by the top level of the 8-point NTT block.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NTT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define NTT_ASSERT(lbl, prop, msg)
`define NTT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ sv/ntt8_pkg.sv @@
// Package for the 8-point NTT mod 12289: types, constants, twiddle tables,
// modular add/sub and butterfly routing functions. No dependencies.
package ntt8_pkg;

  typedef logic [13:0]      coef_t;
  typedef logic [7:0][13:0] vec_t;

  typedef struct packed {
    logic en;
    logic gs;
  } bfly_ctl_t;

  localparam coef_t       Q          = 14'd12289;
  localparam logic [15:0] Q_NEG_INV  = 16'd12287;
  localparam coef_t       SCALE_INV8 = 14'd8192;
  localparam coef_t       MONT_ONE   = 14'd4091;

  localparam int NUM_LAYERS = 3;
  localparam int NUM_LANES  = 4;
  localparam int NUM_COEF   = 8;
  localparam int MONT_LAT   = 3;
  localparam int BFLY_LAT   = MONT_LAT + 2;

  localparam logic [1:0] STRIDE_1 = 2'd0;
  localparam logic [1:0] STRIDE_2 = 2'd1;
  localparam logic [1:0] STRIDE_4 = 2'd2;

  function automatic coef_t add_q(coef_t a, coef_t b);
    logic [14:0] s;
    s = 15'(a) + 15'(b);
    return (s >= 15'(Q)) ? 14'(s - 15'(Q)) : 14'(s);
  endfunction

  function automatic coef_t sub_q(coef_t a, coef_t b);
    return (a >= b) ? 14'(a - b) : 14'(15'(a) + 15'(Q) - 15'(b));
  endfunction

  function automatic coef_t reduce_q(coef_t a);
    return (a >= Q) ? 14'(a - Q) : a;
  endfunction

  // forward layers use strides 4,2,1; inverse layers 1,2,4
  function automatic logic [1:0] layer_stride(logic inv, logic [1:0] layer);
    return inv ? layer : 2'(2'd2 - layer);
  endfunction

  function automatic logic [2:0] pair_lo(logic [1:0] lg, logic [1:0] k);
    logic [2:0] r;
    case (lg)
      STRIDE_4: r = {1'b0, k};
      STRIDE_2: r = {k[1], 1'b0, k[0]};
      default:  r = {k, 1'b0};
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pair_hi(logic [1:0] lg, logic [1:0] k);
    logic [2:0] r;
    case (lg)
      STRIDE_4: r = {1'b1, k};
      STRIDE_2: r = {k[1], 1'b1, k[0]};
      default:  r = {k, 1'b1};
    endcase
    return r;
  endfunction

  function automatic logic [2:0] tw_idx(logic [1:0] lg, logic [1:0] k);
    logic [2:0] r;
    case (lg)
      STRIDE_4: r = 3'd1;
      STRIDE_2: r = {2'b01, k[1]};
      default:  r = {1'b1, k};
    endcase
    return r;
  endfunction

  function automatic coef_t twiddle(logic inv, logic [2:0] idx);
    coef_t w;
    case (idx)
      3'd1:    w = inv ? 14'd4401 : 14'd7888;
      3'd2:    w = inv ? 14'd1081 : 14'd11060;
      3'd3:    w = inv ? 14'd1229 : 14'd11208;
      3'd4:    w = inv ? 14'd2530 : 14'd6960;
      3'd5:    w = inv ? 14'd6014 : 14'd4342;
      3'd6:    w = inv ? 14'd7947 : 14'd6275;
      3'd7:    w = inv ? 14'd5329 : 14'd9759;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ sv/ntt8_mont.sv @@
// Three-stage pipelined Montgomery multiplier, R = 2^16, modulo 12289.
// Depends on ntt8_pkg.
module ntt8_mont (
  input  logic          clk_i,
  input  logic          en_i,
  input  ntt8_pkg::coef_t a_i,
  input  ntt8_pkg::coef_t b_i,
  output ntt8_pkg::coef_t r_o
);

  logic [27:0] prod_q, prod2_q;
  logic [15:0] m_q;
  logic [30:0] sum;
  logic [14:0] t;
  ntt8_pkg::coef_t r_q;

  assign sum = 31'(prod2_q) + 31'(m_q) * 31'(ntt8_pkg::Q);
  assign t   = sum[30:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= 28'(a_i) * 28'(b_i);
      m_q     <= 16'(prod_q[15:0] * ntt8_pkg::Q_NEG_INV);
      prod2_q <= prod_q;
      r_q     <= (t >= 15'(ntt8_pkg::Q)) ? 14'(t - 15'(ntt8_pkg::Q)) : 14'(t);
    end
  end

  assign r_o = r_q;

endmodule

@@ sv/ntt8_bfly.sv @@
// Five-stage butterfly lane: Cooley-Tukey (multiply, then add/sub) or
// Gentleman-Sande (add/sub, then multiply). Depends on ntt8_pkg, ntt8_mont.
module ntt8_bfly (
  input  logic                clk_i,
  input  ntt8_pkg::bfly_ctl_t ctl_i,
  input  ntt8_pkg::coef_t     a_i,
  input  ntt8_pkg::coef_t     b_i,
  input  ntt8_pkg::coef_t     w_i,
  output ntt8_pkg::coef_t     x_o,
  output ntt8_pkg::coef_t     y_o
);

  ntt8_pkg::coef_t u_q, v_q, w_q, x_q, y_q, p;
  ntt8_pkg::coef_t u_dly_q [ntt8_pkg::MONT_LAT];
  logic [ntt8_pkg::MONT_LAT:0] gs_q;

  ntt8_mont u_mont (
    .clk_i (clk_i),
    .en_i  (ctl_i.en),
    .a_i   (v_q),
    .b_i   (w_q),
    .r_o   (p)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      u_q  <= ctl_i.gs ? ntt8_pkg::add_q(a_i, b_i) : a_i;
      v_q  <= ctl_i.gs ? ntt8_pkg::sub_q(a_i, b_i) : b_i;
      w_q  <= w_i;
      gs_q <= {gs_q[ntt8_pkg::MONT_LAT-1:0], ctl_i.gs};
      u_dly_q[0] <= u_q;
      for (int i = 1; i < ntt8_pkg::MONT_LAT; i++) begin
        u_dly_q[i] <= u_dly_q[i-1];
      end
      if (gs_q[ntt8_pkg::MONT_LAT]) begin
        x_q <= u_dly_q[ntt8_pkg::MONT_LAT-1];
        y_q <= p;
      end else begin
        x_q <= ntt8_pkg::add_q(u_dly_q[ntt8_pkg::MONT_LAT-1], p);
        y_q <= ntt8_pkg::sub_q(u_dly_q[ntt8_pkg::MONT_LAT-1], p);
      end
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

@@ sv/ntt8_mod12289_forward_inverse.sv @@
// Top level of the 8-point NTT/INTT modulo 12289.
// Depends on ntt8_pkg, ntt8_bfly, ntt8_mont and assert_macros.svh.
//
// Accepts one item of eight coefficients per clock while the output is not
// stalled and returns its transform after one input reduction stage, three
// butterfly layers of four lanes and a final Montgomery scaling row (scale
// by 8192 in inverse mode, by R mod q in forward mode). The pipeline
// advances as one unit; it stalls only while a result sits unaccepted in the
// output stage. inverse_mode is registered on cfg_valid_i, sampled when an
// item enters and travels with it; write it only while no item is in flight.
`include "assert_macros.svh"
module ntt8_mod12289_forward_inverse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            inverse_mode_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ntt8_pkg::coef_t coef_in_0_i,
  input  ntt8_pkg::coef_t coef_in_1_i,
  input  ntt8_pkg::coef_t coef_in_2_i,
  input  ntt8_pkg::coef_t coef_in_3_i,
  input  ntt8_pkg::coef_t coef_in_4_i,
  input  ntt8_pkg::coef_t coef_in_5_i,
  input  ntt8_pkg::coef_t coef_in_6_i,
  input  ntt8_pkg::coef_t coef_in_7_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ntt8_pkg::coef_t coef_out_0_o,
  output ntt8_pkg::coef_t coef_out_1_o,
  output ntt8_pkg::coef_t coef_out_2_o,
  output ntt8_pkg::coef_t coef_out_3_o,
  output ntt8_pkg::coef_t coef_out_4_o,
  output ntt8_pkg::coef_t coef_out_5_o,
  output ntt8_pkg::coef_t coef_out_6_o,
  output ntt8_pkg::coef_t coef_out_7_o
);

  localparam int MD_LAST = ntt8_pkg::NUM_LAYERS * ntt8_pkg::BFLY_LAT;
  localparam int LAST    = MD_LAST + ntt8_pkg::MONT_LAT;

  logic               inv_mode_q;
  logic [LAST:0]      vld_q;
  logic [MD_LAST:0]   md_q;
  logic               en;
  ntt8_pkg::vec_t     in_vec, c0_q;
  ntt8_pkg::vec_t     vec [ntt8_pkg::NUM_LAYERS+1];
  ntt8_pkg::coef_t    sc_r [ntt8_pkg::NUM_COEF];
  ntt8_pkg::coef_t    sc_w;

  assign cfg_ready_o = 1'b1;
  assign en          = !vld_q[LAST] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAST];

  assign in_vec = {coef_in_7_i, coef_in_6_i, coef_in_5_i, coef_in_4_i,
                   coef_in_3_i, coef_in_2_i, coef_in_1_i, coef_in_0_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mode_q <= 1'b0;
      vld_q      <= '0;
      md_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        inv_mode_q <= inverse_mode_i;
      end
      if (en) begin
        vld_q <= {vld_q[LAST-1:0], in_valid_i};
        md_q  <= {md_q[MD_LAST-1:0], inv_mode_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < ntt8_pkg::NUM_COEF; k++) begin
        c0_q[k] <= ntt8_pkg::reduce_q(in_vec[k]);
      end
    end
  end

  assign vec[0] = c0_q;

  for (genvar l = 0; l < ntt8_pkg::NUM_LAYERS; l++) begin : g_layer
    logic [1:0]          lg_in, lg_out;
    ntt8_pkg::bfly_ctl_t ctl;
    ntt8_pkg::coef_t     a [ntt8_pkg::NUM_LANES];
    ntt8_pkg::coef_t     b [ntt8_pkg::NUM_LANES];
    ntt8_pkg::coef_t     w [ntt8_pkg::NUM_LANES];
    ntt8_pkg::coef_t     x [ntt8_pkg::NUM_LANES];
    ntt8_pkg::coef_t     y [ntt8_pkg::NUM_LANES];
    ntt8_pkg::vec_t      vo;

    assign lg_in  = ntt8_pkg::layer_stride(md_q[ntt8_pkg::BFLY_LAT*l], 2'(l));
    assign lg_out = ntt8_pkg::layer_stride(md_q[ntt8_pkg::BFLY_LAT*(l+1)], 2'(l));
    assign ctl.en = en;
    assign ctl.gs = md_q[ntt8_pkg::BFLY_LAT*l];

    always_comb begin
      for (int k = 0; k < ntt8_pkg::NUM_LANES; k++) begin
        a[k] = vec[l][ntt8_pkg::pair_lo(lg_in, 2'(k))];
        b[k] = vec[l][ntt8_pkg::pair_hi(lg_in, 2'(k))];
        w[k] = ntt8_pkg::twiddle(ctl.gs, ntt8_pkg::tw_idx(lg_in, 2'(k)));
      end
    end

    for (genvar k = 0; k < ntt8_pkg::NUM_LANES; k++) begin : g_lane
      ntt8_bfly u_bfly (
        .clk_i (clk_i),
        .ctl_i (ctl),
        .a_i   (a[k]),
        .b_i   (b[k]),
        .w_i   (w[k]),
        .x_o   (x[k]),
        .y_o   (y[k])
      );
    end

    always_comb begin
      vo = '0;
      for (int k = 0; k < ntt8_pkg::NUM_LANES; k++) begin
        vo[ntt8_pkg::pair_lo(lg_out, 2'(k))] = x[k];
        vo[ntt8_pkg::pair_hi(lg_out, 2'(k))] = y[k];
      end
    end

    assign vec[l+1] = vo;
  end

  // final row: scale by 1/8 for inverse, Montgomery identity for forward
  assign sc_w = md_q[MD_LAST] ? ntt8_pkg::SCALE_INV8 : ntt8_pkg::MONT_ONE;

  for (genvar k = 0; k < ntt8_pkg::NUM_COEF; k++) begin : g_scale
    ntt8_mont u_scale (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (vec[ntt8_pkg::NUM_LAYERS][k]),
      .b_i   (sc_w),
      .r_o   (sc_r[k])
    );
  end

  assign coef_out_0_o = sc_r[0];
  assign coef_out_1_o = sc_r[1];
  assign coef_out_2_o = sc_r[2];
  assign coef_out_3_o = sc_r[3];
  assign coef_out_4_o = sc_r[4];
  assign coef_out_5_o = sc_r[5];
  assign coef_out_6_o = sc_r[6];
  assign coef_out_7_o = sc_r[7];

  `NTT_ASSERT(a_stall_blocks_in, out_valid_o && !out_ready_i |-> !in_ready_o, "stall leak")
  `NTT_ASSERT(a_empty_out_ready, !out_valid_o |-> in_ready_o, "ready low with empty output")
  `NTT_ASSERT(a_accept_enters, in_valid_i && in_ready_o |=> vld_q[0], "accepted item lost")
  `NTT_ASSERT(a_out_range, out_valid_o |-> coef_out_0_o < ntt8_pkg::Q && coef_out_1_o < ntt8_pkg::Q && coef_out_2_o < ntt8_pkg::Q && coef_out_3_o < ntt8_pkg::Q && coef_out_4_o < ntt8_pkg::Q && coef_out_5_o < ntt8_pkg::Q && coef_out_6_o < ntt8_pkg::Q && coef_out_7_o < ntt8_pkg::Q, "result not reduced")
  `NTT_ASSERT_RST(a_reset_clears, !rst_ni |=> !out_valid_o, "valid after reset")

endmodule
